// ----- hdl/vrrp_pkg.sv -----
// Shared types and codes for the VRRP router state machine.
`default_nettype none

package vrrp_pkg;

   localparam int INTERVAL_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   // command codes
   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_ADVERT   = 2'd1;
   localparam logic [1:0] CMD_SHUTDOWN = 2'd2;

   // router state codes
   localparam logic [1:0] MODE_INIT     = 2'd0;
   localparam logic [1:0] MODE_BACKUP   = 2'd1;
   localparam logic [1:0] MODE_MASTER   = 2'd2;
   localparam logic [1:0] MODE_SHUTDOWN = 2'd3;

   localparam logic [7:0] OWNER_PRIORITY = 8'd255;
   localparam logic [7:0] LEAVING_PRIORITY = 8'd0;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_PRIORITY   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREEMPT_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_VRID       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADVERT_INT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASTER_DOWN    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKEW_TICKS     = 3'd6;

   typedef struct packed {
      logic [7:0]            own_priority;
      logic                  preempt_enable;
      logic [31:0]           own_address;
      logic [7:0]            own_vrid;
      logic [INTERVAL_W-1:0] advert_interval;
      logic [INTERVAL_W-1:0] down_interval;
      logic [INTERVAL_W-1:0] skew_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      own_priority:    8'd100,
      preempt_enable:  1'b1,
      own_address:     32'd0,
      own_vrid:        8'd1,
      advert_interval: 16'd100,
      down_interval:   16'd300,
      skew_ticks:      16'd60
   };

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  rx_vrid;
      logic [7:0]  rx_priority;
      logic [31:0] rx_address;
      logic        auth_ok;
   } req_type;

   typedef struct packed {
      logic [1:0] router_state;
      logic       send_advert;
      logic [7:0] advert_priority;
      logic       send_gratuitous_arp;
      logic       arp_table_update;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/vrrp_router_state_machine_core.sv -----
// Top level of the VRRP router state machine: handshakes, registers, state.
//
// Usage:
//   req_* carries one beat per event: a tick, a received advertisement or a
//   shutdown request. Each beat yields exactly one rsp_* beat with the state
//   after the event and the actions to take (advertise, gratuitous ARP,
//   ARP table refresh). csr_* writes the seven configuration registers; write
//   them only while no beat is in flight.
//   A beat is captured in the input register when accepted, then moves to the
//   result register, from which it is presented on rsp_*.
//   Throughput: one beat per cycle while rsp_ready is high. The state and
//   countdown update in the same cycle the beat moves from the input register
//   to the result register, so the next beat sees them at once.
//   Reset: synchronous, active high. State returns to init, the countdown to
//   zero, configuration registers to defaults, both pipeline stages empty.
//   Stall: while rsp_ready is low the result holds; the input register still
//   takes one more beat, then req_ready drops until the result is taken.
`default_nettype none

module vrrp_router_state_machine_core #(
   parameter int TIMER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_rx_vrid,
   input  logic [7:0]  req_rx_priority,
   input  logic [31:0] req_rx_address,
   input  logic        req_auth_ok,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_router_state,
   output logic        rsp_send_advert,
   output logic [7:0]  rsp_advert_priority,
   output logic        rsp_send_gratuitous_arp,
   output logic        rsp_arp_table_update,

   input  logic        csr_we,
   input  logic [vrrp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vrrp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import vrrp_pkg::*;

   cfg_type               cfg_ff, cfg_in;
   logic                  s1_valid_ff, s1_valid_in;
   req_type               s1_item_ff, s1_item_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [1:0]            mode_ff, mode_in;
   logic [TIMER_BITS-1:0] countdown_ff, countdown_in;

   logic                  req_fire;
   logic                  out_free;
   logic                  s1_fire;
   logic [1:0]            mode_calc;
   logic [TIMER_BITS-1:0] countdown_calc;
   rsp_type               rsp_calc;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OWN_PRIORITY:   cfg_in.own_priority = csr_wdata[7:0];
            CSR_PREEMPT_ENABLE: cfg_in.preempt_enable = csr_wdata[0];
            CSR_OWN_ADDRESS:    cfg_in.own_address = csr_wdata[31:0];
            CSR_OWN_VRID:       cfg_in.own_vrid = csr_wdata[7:0];
            CSR_ADVERT_INT:     cfg_in.advert_interval = csr_wdata[INTERVAL_W-1:0];
            CSR_MASTER_DOWN:    cfg_in.down_interval = csr_wdata[INTERVAL_W-1:0];
            CSR_SKEW_TICKS:     cfg_in.skew_ticks = csr_wdata[INTERVAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   vrrp_sm_next #(
      .TIMER_BITS(TIMER_BITS)
   ) u_next (
      .cfg            (cfg_ff),
      .item           (s1_item_ff),
      .mode           (mode_ff),
      .countdown      (countdown_ff),
      .mode_next      (mode_calc),
      .countdown_next (countdown_calc),
      .rsp            (rsp_calc)
   );

   always_comb begin
      s1_item_in = s1_item_ff;
      if (req_fire) begin
         s1_item_in = '{
            command:     req_command,
            rx_vrid:     req_rx_vrid,
            rx_priority: req_rx_priority,
            rx_address:  req_rx_address,
            auth_ok:     req_auth_ok
         };
      end
      s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = s1_fire ? rsp_calc : rsp_ff;
      mode_in      = s1_fire ? mode_calc : mode_ff;
      countdown_in = s1_fire ? countdown_calc : countdown_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_INIT;
         countdown_ff <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         countdown_ff <= countdown_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_router_state        = rsp_ff.router_state;
   assign rsp_send_advert         = rsp_ff.send_advert;
   assign rsp_advert_priority     = rsp_ff.advert_priority;
   assign rsp_send_gratuitous_arp = rsp_ff.send_gratuitous_arp;
   assign rsp_arp_table_update    = rsp_ff.arp_table_update;

   // a takeover always lands in master with an ARP refresh
   a_garp_master: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.send_gratuitous_arp |->
         (rsp_ff.router_state == MODE_MASTER) && rsp_ff.arp_table_update)
      else $error("gratuitous ARP without becoming master");

   // priority field is zero unless an advertisement goes out
   a_prio_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.send_advert |-> rsp_ff.advert_priority == 8'd0)
      else $error("advert priority set without an advertisement");

   // shutdown is sticky until reset
   a_shutdown_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_SHUTDOWN |=> mode_ff == MODE_SHUTDOWN)
      else $error("left shutdown state without reset");

   // result register reflects the state just committed
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff && (rsp_ff.router_state == mode_ff))
      else $error("result state disagrees with stored state");

endmodule

`default_nettype wire

// ----- hdl/vrrp_sm_next.sv -----
// Next-state and action logic for one beat of the VRRP router state machine.
`default_nettype none

module vrrp_sm_next #(
   parameter int TIMER_BITS = 16
) (
   input  vrrp_pkg::cfg_type  cfg,
   input  vrrp_pkg::req_type  item,
   input  logic [1:0]         mode,
   input  logic [TIMER_BITS-1:0] countdown,
   output logic [1:0]         mode_next,
   output logic [TIMER_BITS-1:0] countdown_next,
   output vrrp_pkg::rsp_type  rsp
);
   import vrrp_pkg::*;

   localparam int LOAD_W = (TIMER_BITS > INTERVAL_W) ? TIMER_BITS : INTERVAL_W;
   localparam logic [LOAD_W-1:0] TIMER_MAX = LOAD_W'({TIMER_BITS{1'b1}});

   // intervals wider than the countdown saturate
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [INTERVAL_W-1:0] v);
      logic [LOAD_W-1:0] ext;
      ext = LOAD_W'(v);
      if (ext > TIMER_MAX) begin
         timer_load = {TIMER_BITS{1'b1}};
      end else begin
         timer_load = TIMER_BITS'(ext);
      end
   endfunction

   logic [TIMER_BITS-1:0] load_advert;
   logic [TIMER_BITS-1:0] load_down;
   logic [TIMER_BITS-1:0] load_skew;
   logic                  active;
   logic                  adv_counts;
   logic                  expire;
   logic                  master_loses;

   assign load_advert = timer_load(cfg.advert_interval);
   assign load_down   = timer_load(cfg.down_interval);
   assign load_skew   = timer_load(cfg.skew_ticks);

   assign active = (mode == MODE_BACKUP) || (mode == MODE_MASTER);
   assign adv_counts = item.auth_ok && (item.rx_vrid == cfg.own_vrid) && active;
   assign master_loses = (item.rx_priority != LEAVING_PRIORITY) &&
                         ((item.rx_priority > cfg.own_priority) ||
                          ((item.rx_priority == cfg.own_priority) &&
                           (item.rx_address > cfg.own_address)));

   always_comb begin
      mode_next      = mode;
      countdown_next = countdown;
      expire         = 1'b0;
      rsp            = '0;
      case (item.command)
         CMD_TICK: begin
            if (mode == MODE_INIT) begin
               if (cfg.own_priority == OWNER_PRIORITY) begin
                  expire = 1'b1;
               end else begin
                  mode_next      = MODE_BACKUP;
                  countdown_next = load_down;
               end
            end else if (active) begin
               if (countdown <= TIMER_BITS'(1)) begin
                  expire = 1'b1;
               end else begin
                  countdown_next = countdown - TIMER_BITS'(1);
               end
            end
            if (expire) begin
               rsp.send_advert     = 1'b1;
               rsp.advert_priority = cfg.own_priority;
               countdown_next      = load_advert;
               if (mode != MODE_MASTER) begin
                  mode_next               = MODE_MASTER;
                  rsp.send_gratuitous_arp = 1'b1;
                  rsp.arp_table_update    = 1'b1;
               end
            end
         end
         CMD_ADVERT: begin
            if (adv_counts) begin
               countdown_next = '0;
               if (mode == MODE_BACKUP) begin
                  if (item.rx_priority == LEAVING_PRIORITY) begin
                     countdown_next = load_skew;
                  end else if (!cfg.preempt_enable ||
                               (item.rx_priority >= cfg.own_priority)) begin
                     countdown_next = load_down;
                  end
               end else if (master_loses) begin
                  mode_next      = MODE_BACKUP;
                  countdown_next = load_down;
               end
            end
         end
         CMD_SHUTDOWN: begin
            if (mode == MODE_MASTER) begin
               rsp.send_advert      = 1'b1;
               rsp.advert_priority  = LEAVING_PRIORITY;
               rsp.arp_table_update = 1'b1;
            end
            mode_next = MODE_SHUTDOWN;
         end
         default: begin
         end
      endcase
      rsp.router_state = mode_next;
   end

endmodule

`default_nettype wire

// ----- tb/tb_vrrp_router_state_machine_core.sv -----
// Self-checking testbench for the VRRP router state machine core.
`timescale 1ns / 1ps

module tb_vrrp_router_state_machine_core;
   import vrrp_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int NUM_CSR = 7;
   localparam int RANDOM_PHASES = 8;
   localparam int EVENTS_PER_PHASE = 80;
   localparam int EXTREME_PHASE = 2;
   localparam int PRESSURE_PHASE = 4;
   localparam int HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_TICK;
   logic [7:0]  req_rx_vrid = '0;
   logic [7:0]  req_rx_priority = '0;
   logic [31:0] req_rx_address = '0;
   logic        req_auth_ok = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_router_state;
   logic        rsp_send_advert;
   logic [7:0]  rsp_advert_priority;
   logic        rsp_send_gratuitous_arp;
   logic        rsp_arp_table_update;

   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   vrrp_router_state_machine_core DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_command             (req_command),
      .req_rx_vrid             (req_rx_vrid),
      .req_rx_priority         (req_rx_priority),
      .req_rx_address          (req_rx_address),
      .req_auth_ok             (req_auth_ok),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_router_state        (rsp_router_state),
      .rsp_send_advert         (rsp_send_advert),
      .rsp_advert_priority     (rsp_advert_priority),
      .rsp_send_gratuitous_arp (rsp_send_gratuitous_arp),
      .rsp_arp_table_update    (rsp_arp_table_update),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   // shadow of the router: settings, state and countdown
   cfg_type          cfg_shadow = CFG_RESET;
   logic [1:0]       mode_q = MODE_INIT;
   logic [INTERVAL_W-1:0] countdown_q = '0;

   req_type pending_events[$];
   rsp_type predicted_actions[$];
   req_type next_event;
   req_type seen_event;
   rsp_type due;

   int items_queued = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int error_count = 0;
   int settings_applied = 0;
   int adverts_due = 0;
   int takeovers_due = 0;
   int quiet_cycles = 0;

   logic req_fire = 1'b0;
   int   gap_left = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   int   hold_requests = 0;
   int   holds_done = 0;
   bit   gaps_on = 1'b1;
   bit   stalls_on = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic rsp_type vrrp_advance(input req_type ev);
      rsp_type act;
      logic    timeout;
      act = '0;
      timeout = 1'b0;
      case (ev.command)
         CMD_TICK: begin
            if (mode_q == MODE_INIT) begin
               if (cfg_shadow.own_priority == OWNER_PRIORITY) begin
                  timeout = 1'b1;
               end else begin
                  mode_q = MODE_BACKUP;
                  countdown_q = cfg_shadow.down_interval;
               end
            end else if (mode_q == MODE_BACKUP || mode_q == MODE_MASTER) begin
               if (countdown_q <= INTERVAL_W'(1)) timeout = 1'b1;
               else countdown_q = countdown_q - INTERVAL_W'(1);
            end
            if (timeout) begin
               act.send_advert = 1'b1;
               act.advert_priority = cfg_shadow.own_priority;
               countdown_q = cfg_shadow.advert_interval;
               if (mode_q != MODE_MASTER) begin
                  mode_q = MODE_MASTER;
                  act.send_gratuitous_arp = 1'b1;
                  act.arp_table_update = 1'b1;
               end
            end
         end
         CMD_ADVERT: begin
            if (ev.auth_ok && ev.rx_vrid == cfg_shadow.own_vrid &&
                (mode_q == MODE_BACKUP || mode_q == MODE_MASTER)) begin
               countdown_q = '0;
               if (mode_q == MODE_BACKUP) begin
                  if (ev.rx_priority == LEAVING_PRIORITY)
                     countdown_q = cfg_shadow.skew_ticks;
                  else if (!cfg_shadow.preempt_enable ||
                           ev.rx_priority >= cfg_shadow.own_priority)
                     countdown_q = cfg_shadow.down_interval;
                  // else: stays at zero, preempts on next tick
               end else if (ev.rx_priority != LEAVING_PRIORITY &&
                            (ev.rx_priority > cfg_shadow.own_priority ||
                             (ev.rx_priority == cfg_shadow.own_priority &&
                              ev.rx_address > cfg_shadow.own_address))) begin
                  mode_q = MODE_BACKUP;
                  countdown_q = cfg_shadow.down_interval;
               end
            end
         end
         CMD_SHUTDOWN: begin
            if (mode_q == MODE_MASTER) begin
               act.send_advert = 1'b1;
               act.advert_priority = LEAVING_PRIORITY;
               act.arp_table_update = 1'b1;
            end
            mode_q = MODE_SHUTDOWN;
         end
         default: ;
      endcase
      act.router_state = mode_q;
      return act;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_actions.size() == 0) begin
               report_mismatch("result beat with no event waiting");
            end else begin
               due = predicted_actions.pop_front();
               check_field("router_state", int'(rsp_router_state),
                           int'(due.router_state));
               check_field("send_advert", int'(rsp_send_advert),
                           int'(due.send_advert));
               check_field("advert_priority", int'(rsp_advert_priority),
                           int'(due.advert_priority));
               check_field("send_gratuitous_arp", int'(rsp_send_gratuitous_arp),
                           int'(due.send_gratuitous_arp));
               check_field("arp_table_update", int'(rsp_arp_table_update),
                           int'(due.arp_table_update));
            end
            results_checked <= results_checked + 1;
         end
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            seen_event.command = req_command;
            seen_event.rx_vrid = req_rx_vrid;
            seen_event.rx_priority = req_rx_priority;
            seen_event.rx_address = req_rx_address;
            seen_event.auth_ok = req_auth_ok;
            due = vrrp_advance(seen_event);
            adverts_due += int'(due.send_advert);
            takeovers_due += int'(due.send_gratuitous_arp);
            predicted_actions.push_back(due);
            items_accepted <= items_accepted + 1;
         end
      end
   end

   // watchdog: cycles without any beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", quiet_cycles);
         $display("tb_vrrp_router_state_machine_core: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- driving
   function automatic int pick_idle_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            next_event = pending_events.pop_front();
            req_valid <= 1'b1;
            req_command <= next_event.command;
            req_rx_vrid <= next_event.rx_vrid;
            req_rx_priority <= next_event.rx_priority;
            req_rx_address <= next_event.rx_address;
            req_auth_ok <= next_event.auth_ok;
            if (gaps_on && $urandom_range(0, 2) == 0) gap_left = pick_idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus the long hold-off on request
   always @(negedge clock) begin
      if (hold_requests != holds_done) begin
         holds_done = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_idle_len();
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic queue_event(input logic [1:0] cmd, input logic [7:0] vrid,
                              input logic [7:0] prio, input logic [31:0] addr,
                              input logic auth);
      req_type ev;
      ev.command = cmd;
      ev.rx_vrid = vrid;
      ev.rx_priority = prio;
      ev.rx_address = addr;
      ev.auth_ok = auth;
      pending_events.push_back(ev);
      items_queued++;
   endtask

   task automatic queue_random_event();
      logic [1:0]  cmd;
      logic [7:0]  vrid;
      logic [7:0]  prio;
      logic [31:0] addr;
      logic        auth;
      int          pick;
      pick = $urandom_range(0, 99);
      cmd = CMD_ADVERT;
      vrid = cfg_shadow.own_vrid;
      auth = 1'b1;
      // priorities and addresses cluster around our own for the tie breaks
      case ($urandom_range(0, 5))
         0: prio = LEAVING_PRIORITY;
         1: prio = cfg_shadow.own_priority;
         2: prio = cfg_shadow.own_priority + 8'd1;
         3: prio = cfg_shadow.own_priority - 8'd1;
         default: prio = 8'($urandom());
      endcase
      case ($urandom_range(0, 3))
         0: addr = cfg_shadow.own_address;
         1: addr = cfg_shadow.own_address + 32'd1;
         2: addr = cfg_shadow.own_address - 32'd1;
         default: addr = $urandom();
      endcase
      if (pick < 50) begin
         cmd = CMD_TICK;
         vrid = 8'($urandom());
         auth = 1'($urandom_range(0, 1));
      end else if (pick < 54) begin
         auth = 1'b0;
      end else if (pick < 58) begin
         vrid = 8'($urandom());
      end else if (pick < 62) begin
         cmd = CMD_UNUSED;
         vrid = 8'($urandom());
         auth = 1'($urandom_range(0, 1));
      end
      queue_event(cmd, vrid, prio, addr, auth);
   endtask

   task automatic apply_settings(input cfg_type c);
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  data;
      for (int i = 0; i < NUM_CSR; i++) begin
         idx = CSR_INDEX_W'(i);
         case (idx)
            CSR_OWN_PRIORITY:   data = CSR_DATA_W'(c.own_priority);
            CSR_PREEMPT_ENABLE: data = CSR_DATA_W'(c.preempt_enable);
            CSR_OWN_ADDRESS:    data = c.own_address;
            CSR_OWN_VRID:       data = CSR_DATA_W'(c.own_vrid);
            CSR_ADVERT_INT:     data = CSR_DATA_W'(c.advert_interval);
            CSR_MASTER_DOWN:    data = CSR_DATA_W'(c.down_interval);
            default:            data = CSR_DATA_W'(c.skew_ticks);
         endcase
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
      end
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_shadow = c;
      settings_applied++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (items_accepted != items_queued || results_checked != items_accepted);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      cfg_type draw;
      logic [7:0] vrid;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // address owner: takes over on the first tick, then is beaten on a tie
      draw = CFG_RESET;
      draw.own_priority = OWNER_PRIORITY;
      draw.own_address = 32'h8000_0000;
      draw.own_vrid = 8'd255;
      draw.advert_interval = 16'd2;
      draw.down_interval = 16'd3;
      draw.skew_ticks = 16'd0;
      apply_settings(draw);
      @(posedge clock);
      vrid = draw.own_vrid;
      queue_event(CMD_ADVERT, vrid, 8'd200, 32'd0, 1'b1);          // ignored in init
      queue_event(CMD_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      queue_event(CMD_TICK, 8'd0, 8'd0, 32'd0, 1'b0);
      queue_event(CMD_TICK, 8'd0, 8'd0, 32'd0, 1'b0);
      queue_event(CMD_TICK, 8'd0, 8'd0, 32'd0, 1'b0);
      queue_event(CMD_ADVERT, 8'd0, 8'd255, 32'hFFFF_FFFF, 1'b1);  // wrong VRID
      queue_event(CMD_ADVERT, vrid, 8'd255, 32'hFFFF_FFFF, 1'b0);  // failed auth
      queue_event(CMD_ADVERT, vrid, LEAVING_PRIORITY, 32'd5, 1'b1);
      queue_event(CMD_TICK, 8'd0, 8'd0, 32'd0, 1'b0);
      queue_event(CMD_ADVERT, vrid, 8'd255, 32'd0, 1'b1);          // tie, lower address
      queue_event(CMD_ADVERT, vrid, 8'd255, 32'hFFFF_FFFF, 1'b1);  // tie, higher address
      queue_event(CMD_ADVERT, vrid, LEAVING_PRIORITY, 32'd1, 1'b1);
      queue_event(CMD_TICK, 8'd0, 8'd0, 32'd0, 1'b0);
      queue_event(CMD_UNUSED, 8'd0, 8'd0, 32'd0, 1'b0);
      queue_event(CMD_ADVERT, vrid, 8'd255, 32'hFFFF_FFFF, 1'b1);
      wait_drained();

      draw = CFG_RESET;
      draw.advert_interval = 16'd1;
      draw.down_interval = 16'd1;
      draw.skew_ticks = 16'd1;
      apply_settings(draw);
      @(posedge clock);
      vrid = draw.own_vrid;
      queue_event(CMD_ADVERT, vrid, 8'd50, 32'd9, 1'b1);           // lower: preempt
      queue_event(CMD_TICK, 8'd0, 8'd0, 32'd0, 1'b0);
      queue_event(CMD_ADVERT, vrid, 8'd101, 32'd0, 1'b1);          // higher: step down
      queue_event(CMD_ADVERT, vrid, 8'd100, 32'd0, 1'b1);
      queue_event(CMD_TICK, 8'd0, 8'd0, 32'd0, 1'b0);
      wait_drained();

      draw.preempt_enable = 1'b0;
      apply_settings(draw);
      @(posedge clock);
      queue_event(CMD_ADVERT, vrid, 8'd101, 32'd0, 1'b1);
      queue_event(CMD_ADVERT, vrid, 8'd50, 32'd0, 1'b1);           // no preempt
      queue_event(CMD_ADVERT, vrid, LEAVING_PRIORITY, 32'd0, 1'b1);
      queue_event(CMD_TICK, 8'd0, 8'd0, 32'd0, 1'b0);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 2))
            0: draw.own_priority = 8'd1;
            1: draw.own_priority = OWNER_PRIORITY;
            default: draw.own_priority = 8'($urandom_range(1, 254));
         endcase
         draw.preempt_enable = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 2))
            0: draw.own_address = '0;
            1: draw.own_address = '1;
            default: draw.own_address = $urandom();
         endcase
         case ($urandom_range(0, 2))
            0: draw.own_vrid = 8'd1;
            1: draw.own_vrid = 8'd255;
            default: draw.own_vrid = 8'($urandom_range(1, 255));
         endcase
         if (phase == EXTREME_PHASE) begin
            draw.own_priority = 8'd1;
            draw.advert_interval = '1;
            draw.down_interval = '1;
            draw.skew_ticks = '1;
         end else begin
            draw.advert_interval = INTERVAL_W'($urandom_range(1, 6));
            draw.down_interval = INTERVAL_W'($urandom_range(1, 8));
            draw.skew_ticks = INTERVAL_W'($urandom_range(0, 4));
         end
         apply_settings(draw);
         @(posedge clock);
         gaps_on = (phase != PRESSURE_PHASE) && ($urandom_range(0, 3) != 0);
         stalls_on = $urandom_range(0, 3) != 0;
         repeat (EVENTS_PER_PHASE) queue_random_event();
         if (phase == PRESSURE_PHASE) hold_requests++;
         wait_drained();
      end

      // leave as master, then exercise the inert shutdown state
      draw.down_interval = 16'd1;
      draw.skew_ticks = 16'd0;
      apply_settings(draw);
      @(posedge clock);
      gaps_on = 1'b1;
      vrid = draw.own_vrid;
      if (mode_q == MODE_BACKUP) begin
         queue_event(CMD_ADVERT, vrid, LEAVING_PRIORITY, 32'd0, 1'b1);
         queue_event(CMD_TICK, 8'd0, 8'd0, 32'd0, 1'b0);
      end
      queue_event(CMD_SHUTDOWN, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      queue_event(CMD_TICK, 8'd0, 8'd0, 32'd0, 1'b0);
      queue_event(CMD_ADVERT, vrid, 8'd255, 32'hFFFF_FFFF, 1'b1);
      queue_event(CMD_SHUTDOWN, 8'd0, 8'd0, 32'd0, 1'b0);
      queue_event(CMD_UNUSED, 8'd0, 8'd0, 32'd0, 1'b0);
      wait_drained();

      while (predicted_actions.size() != 0) begin
         void'(predicted_actions.pop_front());
         report_mismatch("expected result never arrived");
      end
      $display("Covered %0d events under %0d register settings, incl. a long output",
               items_accepted, settings_applied);
      $display("hold-off and a master shutdown; %0d adverts, %0d takeovers, %0d mismatches",
               adverts_due, takeovers_due, error_count);
      if (error_count == 0) begin
         $display("tb_vrrp_router_state_machine_core: PASS");
      end else begin
         $display("tb_vrrp_router_state_machine_core: FAIL");
      end
      $finish;
   end

endmodule

// ----- vrrp_router_state_machine_core.f -----
hdl/vrrp_pkg.sv
hdl/vrrp_sm_next.sv
hdl/vrrp_router_state_machine_core.sv
tb/tb_vrrp_router_state_machine_core.sv
